FILE: rtl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Used by every allocator module in rtl/ except ffha_ram; no dependencies.
`default_nettype none

package ffha_pkg;

    localparam int MAX_BLOCKS_DEF = 256;
    localparam int HEADER_BYTES   = 16;
    localparam int UNITS_W        = 20;   // payload size in 16-byte units, minus one
    localparam int REQ_W          = 24;
    localparam int ADDR_W         = 32;
    localparam int CFG_IDX_W      = 1;
    localparam int IN_DATA_W      = 56;   // request_size + block_address
    localparam int OUT_DATA_W     = 72;   // 66 bits of fields, padded to bytes

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_ZERO_SIZE    = 2'd1,
        ST_NO_MEMORY    = 2'd2,
        ST_UNKNOWN_FREE = 2'd3
    } ffha_status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture the input transfer, restart the walk
        logic early;    // zero size or null free: answer without a walk
        logic advance;  // issue the next table read
        logic step;     // move the header address past the checked entry
        logic hit;      // checked entry matches: commit
        logic miss;     // walk ended without a match: append or fail
        logic push;     // move the pending result into the output register
    } ffha_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic early;
        logic count_zero;
        logic last;
        logic hit;
        logic out_free;
    } ffha_stat_t;

endpackage : ffha_pkg

`default_nettype wire

FILE: rtl/first_fit_heap_allocator.sv
// First-fit heap allocator: top level joining the sequencer and the datapath.
// Depends on ffha_pkg, ffha_ctrl, ffha_datapath (and ffha_ram below it).
//
// Keeps a table of heap blocks (size in 16-byte units and a used flag) in
// address order, in a MAX_BLOCKS-entry RAM. An allocate takes the first free
// block large enough, or appends a new block; a free walks the table for the
// block whose payload starts at the given address. One request is handled at
// a time, and the walk reads one table entry per cycle through the RAM's
// single read port, accumulating the header address as it goes. Zero-size
// and null-free requests skip the walk. A finished result waits until the
// previous one leaves the output register. The next request is accepted in
// the cycle after the result is loaded. A new request is taken while the
// previous result still waits at the output. Configuration writes must only
// happen while no request is in flight; a write to heap_start empties the
// table.
`default_nettype none

module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [ffha_pkg::IN_DATA_W-1:0]  s_tdata,   // request_size[23:0], block_address[55:24]
    input  wire logic                            s_tuser,   // action: 0 allocate, 1 free
    // result channel
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [ffha_pkg::OUT_DATA_W-1:0] m_tdata,   // result_address[31:0], status[33:32],
                                                            // bytes_in_use[65:34], zero pad
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [ffha_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ffha_pkg::ADDR_W-1:0]     cfg_data
);

    import ffha_pkg::*;

    ffha_cmd_t  cmd;
    ffha_stat_t st;

    ffha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ffha_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule : first_fit_heap_allocator

`default_nettype wire

FILE: rtl/ffha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule : ffha_ram

`default_nettype wire

FILE: rtl/ffha_ctrl.sv
// Sequencer for the allocator: one request at a time, walking the block table.
// Depends on ffha_pkg.
`default_nettype none

module ffha_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output      logic               s_tready,
    input  wire ffha_pkg::ffha_stat_t st,
    output      ffha_pkg::ffha_cmd_t  cmd
);

    import ffha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (st.early)
                begin
                    cmd.early  = 1'b1;
                    state_next = S_DONE;
                end
                else if (st.count_zero)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (st.hit)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_DONE;
                end
                else if (st.last)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.step    = 1'b1;
                end
            end
            S_DECIDE:
            begin
                cmd.miss   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // at most one commit-type command per cycle
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.early, cmd.hit, cmd.miss, cmd.push}))
        else $error("ffha_ctrl: conflicting commands");

    a_push_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !st.out_free) |=> (state_reg == S_DONE))
        else $error("ffha_ctrl: result dropped while output busy");

    a_scan_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ($past(state_reg) == S_START || $past(state_reg) == S_SCAN))
        else $error("ffha_ctrl: walk entered without priming read");

endmodule : ffha_ctrl

`default_nettype wire

FILE: rtl/ffha_datapath.sv
// Allocator datapath: configuration, block table RAM, header walk, result registers.
// Depends on ffha_pkg and ffha_ram.
`default_nettype none

module ffha_datapath #(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [ffha_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,
    input  wire logic                           cfg_we,
    input  wire logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ffha_pkg::ADDR_W-1:0]    cfg_data,
    input  wire ffha_pkg::ffha_cmd_t            cmd,
    output      ffha_pkg::ffha_stat_t           st,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [ffha_pkg::OUT_DATA_W-1:0] m_tdata
);

    import ffha_pkg::*;

    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    // header address never wraps during a walk; each entry adds less than 2^25
    localparam int HDR_W   = (CNT_W + 26 > 33) ? CNT_W + 26 : 33;
    localparam int SZ_W    = UNITS_W + 5;   // payload bytes
    localparam int STEP_W  = SZ_W + 1;      // payload plus header
    localparam int ENTRY_W = UNITS_W + 1;

    // configuration and heap state
    logic [ADDR_W-1:0] heap_start_reg;
    logic [ADDR_W-1:0] heap_limit_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] append_reg;
    logic [ADDR_W-1:0] used_reg;

    // current request
    logic               act_reg;
    logic               req_zero_reg;
    logic [UNITS_W-1:0] units_reg;
    logic [ADDR_W-1:0]  target_reg;

    // walk
    logic [HDR_W-1:0]  hdr_reg;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [IDX_W-1:0]  chk_idx_reg;

    // results
    logic [ADDR_W-1:0] pend_addr_reg;
    ffha_status_t      pend_status_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    ffha_status_t      out_status_reg;
    logic [ADDR_W-1:0] out_used_reg;

    // table RAM
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               entry_used;
    logic [UNITS_W-1:0] entry_units;

    logic [SZ_W-1:0]    entry_sz;
    logic [STEP_W-1:0]  entry_step;
    logic [STEP_W-1:0]  need_hdr;
    logic [HDR_W-1:0]   payload_addr;
    logic               hit_alloc;
    logic               hit_free;
    logic               table_full;
    logic               heap_short;
    logic [ADDR_W+1:0]  append_end;

    ffha_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign entry_used  = ram_rdata[ENTRY_W-1];
    assign entry_units = ram_rdata[UNITS_W-1:0];

    assign entry_sz     = {(UNITS_W+1)'(entry_units) + (UNITS_W+1)'(1), 4'b0000};
    assign entry_step   = STEP_W'(entry_sz) + STEP_W'(HEADER_BYTES);
    assign need_hdr     = STEP_W'({(UNITS_W+1)'(units_reg) + (UNITS_W+1)'(1), 4'b0000})
                        + STEP_W'(HEADER_BYTES);
    assign payload_addr = hdr_reg + HDR_W'(HEADER_BYTES);

    // sz >= need reduces to a compare of the unit counts
    assign hit_alloc  = !entry_used && (entry_units >= units_reg);
    assign hit_free   = (payload_addr == HDR_W'(target_reg));
    assign table_full = (count_reg == CNT_W'(MAX_BLOCKS));
    // the block may not end at or past the limit; no wrap-around
    assign append_end = (ADDR_W+2)'(append_reg) + (ADDR_W+2)'(need_hdr);
    assign heap_short = (append_end >= (ADDR_W+2)'(heap_limit_reg));

    always_comb
    begin
        st.early      = (act_reg == ACT_ALLOC) ? req_zero_reg : (target_reg == '0);
        st.count_zero = (count_reg == '0);
        st.last       = (scan_idx_reg == count_reg);
        st.hit        = (act_reg == ACT_FREE) ? hit_free : hit_alloc;
        st.out_free   = !out_valid_reg || m_tready;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = chk_idx_reg;
        ram_wdata = {1'b1, entry_units};
        if (cmd.hit)
        begin
            if (act_reg == ACT_ALLOC)
            begin
                ram_we = 1'b1;
            end
            else if (entry_used)
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b0, entry_units};
            end
        end
        else if (cmd.miss && act_reg == ACT_ALLOC && !table_full && !heap_short)
        begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[IDX_W-1:0];
            ram_wdata = {1'b1, units_reg};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_start_reg <= '0;
            heap_limit_reg <= '0;
            count_reg      <= '0;
            append_reg     <= '0;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_HEAP_START)
            begin
                heap_start_reg <= cfg_data;
                count_reg      <= '0;
                append_reg     <= cfg_data;
                used_reg       <= '0;
            end
            else if (cfg_we && cfg_index == CFG_HEAP_LIMIT)
            begin
                heap_limit_reg <= cfg_data;
            end
            else if (cmd.hit)
            begin
                if (act_reg == ACT_ALLOC)
                begin
                    used_reg <= used_reg + ADDR_W'(entry_step);
                end
                else if (entry_used)
                begin
                    used_reg <= used_reg - ADDR_W'(entry_step);
                end
            end
            else if (cmd.miss && act_reg == ACT_ALLOC && !table_full && !heap_short)
            begin
                count_reg  <= count_reg + CNT_W'(1);
                append_reg <= append_reg + ADDR_W'(need_hdr);
                used_reg   <= used_reg + ADDR_W'(need_hdr);
            end

            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg      <= s_tuser;
            req_zero_reg <= (s_tdata[REQ_W-1:0] == '0);
            units_reg    <= s_tdata[REQ_W-1:4];
            target_reg   <= s_tdata[REQ_W +: ADDR_W];
            hdr_reg      <= HDR_W'(heap_start_reg);
            scan_idx_reg <= '0;
        end
        else
        begin
            if (cmd.advance)
            begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                chk_idx_reg  <= scan_idx_reg[IDX_W-1:0];
            end
            if (cmd.step)
            begin
                hdr_reg <= hdr_reg + HDR_W'(entry_step);
            end
        end

        if (cmd.early)
        begin
            pend_addr_reg   <= '0;
            pend_status_reg <= (act_reg == ACT_ALLOC) ? ST_ZERO_SIZE : ST_OK;
        end
        else if (cmd.hit)
        begin
            if (act_reg == ACT_ALLOC)
            begin
                pend_addr_reg   <= payload_addr[ADDR_W-1:0];
                pend_status_reg <= ST_OK;
            end
            else
            begin
                pend_addr_reg   <= '0;
                pend_status_reg <= entry_used ? ST_OK : ST_UNKNOWN_FREE;
            end
        end
        else if (cmd.miss)
        begin
            pend_addr_reg <= '0;
            if (act_reg == ACT_FREE)
            begin
                pend_status_reg <= ST_UNKNOWN_FREE;
            end
            else if (table_full || heap_short)
            begin
                pend_status_reg <= ST_NO_MEMORY;
            end
            else
            begin
                pend_addr_reg   <= append_reg + ADDR_W'(HEADER_BYTES);
                pend_status_reg <= ST_OK;
            end
        end

        if (cmd.push)
        begin
            out_addr_reg   <= pend_addr_reg;
            out_status_reg <= pend_status_reg;
            out_used_reg   <= used_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_used_reg, out_status_reg, out_addr_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("ffha_datapath: block count beyond table size");

    a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !cmd.hit) |-> !table_full)
        else $error("ffha_datapath: append into a full table");

    a_fail_null_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> (out_addr_reg == '0))
        else $error("ffha_datapath: failed request returned an address");

endmodule : ffha_datapath

`default_nettype wire
